FILE: rtl/ipmb_frame_check_classify_defines.svh
// ----------------------------------------------------------------------------
// IPMB frame check assertion macros
// Implication and next-cycle checks with clock and reset, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef IPMB_FRAME_CHECK_CLASSIFY_DEFINES_SVH
`define IPMB_FRAME_CHECK_CLASSIFY_DEFINES_SVH

`ifndef SYNTH
`define IPMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ipmb frame check: same-cycle check failed");
`define IPMB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ipmb frame check: next-cycle check failed");
`else
`define IPMB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define IPMB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/ipmb_fcc_pkg.sv
// ----------------------------------------------------------------------------
// IPMB frame check package
// Status codes, field positions and event constants for the frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ipmb_fcc_pkg;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_HEADER_BAD = 3'd1,
        STATUS_BODY_BAD   = 3'd2,
        STATUS_TOO_SHORT  = 3'd3,
        STATUS_TOO_LONG   = 3'd4
    } status_t;

    localparam int DEFAULT_MAX_FRAME_BYTES = 64;

    localparam int HEADER_BYTES = 3;
    localparam int POS_NETFN    = 1;
    localparam int POS_SOURCE   = 3;
    localparam int POS_SEQUENCE = 4;
    localparam int POS_COMMAND  = 5;

    localparam logic [5:0] EVENT_NETFN   = 6'h3F;
    localparam logic [7:0] EVENT_COMMAND = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/ipmb_fcc_byte_if.sv
// ----------------------------------------------------------------------------
// IPMB frame byte channel
// One frame byte per transfer with a final-byte mark.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipmb_fcc_byte_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);

endinterface

`default_nettype wire

FILE: rtl/ipmb_fcc_result_if.sv
// ----------------------------------------------------------------------------
// IPMB frame result channel
// One check result and the captured header fields per frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipmb_fcc_result_if;

    import ipmb_fcc_pkg::*;

    logic       valid;
    logic       ready;
    status_t    status;
    logic       is_event;
    logic [5:0] net_function;
    logic [7:0] source_address;
    logic [5:0] request_sequence;
    logic [7:0] command_code;
    logic [6:0] frame_length;

    modport source (
        output valid, output status, output is_event, output net_function,
        output source_address, output request_sequence, output command_code,
        output frame_length, input ready
    );
    modport sink (
        input valid, input status, input is_event, input net_function,
        input source_address, input request_sequence, input command_code,
        input frame_length, output ready
    );

endinterface

`default_nettype wire

FILE: rtl/ipmb_frame_check_classify.sv
// ----------------------------------------------------------------------------
// IPMB frame check and classify: header/body checksums, field capture, status
// Final byte: registered at input stage, verdict registered at result stage.
// Throughput: one byte per cycle; a final byte holds in the input register
// while an earlier result waits unaccepted in the result register.
// Reset: async active low clears sums, position, captures and both valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ipmb_frame_check_classify_defines.svh"

module ipmb_frame_check_classify #(
    parameter int MAX_FRAME_BYTES = ipmb_fcc_pkg::DEFAULT_MAX_FRAME_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    ipmb_fcc_byte_if.sink      frame,
    ipmb_fcc_result_if.source  result
);

    import ipmb_fcc_pkg::*;

    localparam int              POS_W   = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       out_free;
    logic       s1_go;
    logic       take;

    // frame state
    logic [7:0]       hdr_sum_reg,  hdr_sum_next,  hdr_acc;
    logic [7:0]       body_sum_reg, body_sum_next, body_acc;
    logic [POS_W-1:0] pos_reg,      pos_next,      pos_acc;
    logic             ovf_reg,      ovf_next,      ovf_acc;
    logic [5:0]       netfn_reg,    netfn_next,    netfn_acc;
    logic [7:0]       source_reg,   source_next,   source_acc;
    logic [5:0]       seq_reg,      seq_next,      seq_acc;
    logic [7:0]       cmd_reg,      cmd_next,      cmd_acc;
    status_t          status_acc;

    // result stage
    logic       out_valid_reg, out_valid_next;
    status_t    out_status_reg;
    logic       out_event_reg;
    logic [5:0] out_netfn_reg;
    logic [7:0] out_source_reg;
    logic [5:0] out_seq_reg;
    logic [7:0] out_cmd_reg;
    logic [6:0] out_len_reg;

    assign out_free    = !out_valid_reg || result.ready;
    assign s1_go       = s1_valid_reg && (!s1_last_reg || out_free);
    assign frame.ready = !s1_valid_reg || s1_go;
    assign take        = frame.valid && frame.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= frame.data_byte;
            s1_last_reg <= frame.last;
        end
    end

    // accumulate one byte into the frame state
    always_comb
    begin
        hdr_acc    = hdr_sum_reg;
        body_acc   = body_sum_reg;
        pos_acc    = pos_reg;
        ovf_acc    = ovf_reg;
        netfn_acc  = netfn_reg;
        source_acc = source_reg;
        seq_acc    = seq_reg;
        cmd_acc    = cmd_reg;
        if (pos_reg >= MAX_POS)
        begin
            ovf_acc = 1'b1;
        end
        else
        begin
            if (pos_reg < POS_W'(HEADER_BYTES))
            begin
                hdr_acc = hdr_sum_reg + s1_byte_reg;
            end
            else
            begin
                body_acc = body_sum_reg + s1_byte_reg;
            end
            case (pos_reg)
                POS_W'(POS_NETFN):    netfn_acc  = s1_byte_reg[7:2];
                POS_W'(POS_SOURCE):   source_acc = s1_byte_reg;
                POS_W'(POS_SEQUENCE): seq_acc    = s1_byte_reg[7:2];
                POS_W'(POS_COMMAND):  cmd_acc    = s1_byte_reg;
                default:              ;
            endcase
            pos_acc = pos_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (ovf_acc)
        begin
            status_acc = STATUS_TOO_LONG;
        end
        else if (pos_acc < POS_W'(HEADER_BYTES))
        begin
            status_acc = STATUS_TOO_SHORT;
        end
        else if (hdr_acc != 8'd0)
        begin
            status_acc = STATUS_HEADER_BAD;
        end
        else if (body_acc != 8'd0)
        begin
            status_acc = STATUS_BODY_BAD;
        end
        else
        begin
            status_acc = STATUS_OK;
        end
    end

    // store the accumulated byte, or clear the frame state after the final byte
    always_comb
    begin
        hdr_sum_next  = hdr_sum_reg;
        body_sum_next = body_sum_reg;
        pos_next      = pos_reg;
        ovf_next      = ovf_reg;
        netfn_next    = netfn_reg;
        source_next   = source_reg;
        seq_next      = seq_reg;
        cmd_next      = cmd_reg;
        if (s1_go && s1_last_reg)
        begin
            hdr_sum_next  = '0;
            body_sum_next = '0;
            pos_next      = '0;
            ovf_next      = 1'b0;
            netfn_next    = '0;
            source_next   = '0;
            seq_next      = '0;
            cmd_next      = '0;
        end
        else if (s1_go)
        begin
            hdr_sum_next  = hdr_acc;
            body_sum_next = body_acc;
            pos_next      = pos_acc;
            ovf_next      = ovf_acc;
            netfn_next    = netfn_acc;
            source_next   = source_acc;
            seq_next      = seq_acc;
            cmd_next      = cmd_acc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_sum_reg  <= '0;
            body_sum_reg <= '0;
            pos_reg      <= '0;
            ovf_reg      <= 1'b0;
            netfn_reg    <= '0;
            source_reg   <= '0;
            seq_reg      <= '0;
            cmd_reg      <= '0;
        end
        else
        begin
            hdr_sum_reg  <= hdr_sum_next;
            body_sum_reg <= body_sum_next;
            pos_reg      <= pos_next;
            ovf_reg      <= ovf_next;
            netfn_reg    <= netfn_next;
            source_reg   <= source_next;
            seq_reg      <= seq_next;
            cmd_reg      <= cmd_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            out_status_reg <= status_acc;
            out_event_reg  <= (netfn_acc == EVENT_NETFN) && (cmd_acc == EVENT_COMMAND);
            out_netfn_reg  <= netfn_acc;
            out_source_reg <= source_acc;
            out_seq_reg    <= seq_acc;
            out_cmd_reg    <= cmd_acc;
            out_len_reg    <= 7'(pos_acc);
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.status           = out_status_reg;
    assign result.is_event         = out_event_reg;
    assign result.net_function     = out_netfn_reg;
    assign result.source_address   = out_source_reg;
    assign result.request_sequence = out_seq_reg;
    assign result.command_code     = out_cmd_reg;
    assign result.frame_length     = out_len_reg;

    `IPMB_ASSERT_IMPLY(a_ovf_at_full, clk, rst_n, ovf_reg, pos_reg == MAX_POS)
    `IPMB_ASSERT_IMPLY(a_pos_bounded, clk, rst_n, 1'b1, pos_reg <= MAX_POS)
    `IPMB_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s1_go && s1_last_reg,
        pos_reg == '0 && !ovf_reg && hdr_sum_reg == 8'd0 && result.valid)
    `IPMB_ASSERT_NEXT(a_stage_holds, clk, rst_n, s1_valid_reg && !s1_go,
        s1_valid_reg && $stable(s1_byte_reg) && $stable(s1_last_reg))
    `IPMB_ASSERT_IMPLY(a_short_len, clk, rst_n,
        result.valid && result.status == STATUS_TOO_SHORT,
        result.frame_length < 7'd3 && !result.is_event)

endmodule

`default_nettype wire

FILE: test/ipmb_frame_check_classify_tb.sv
// ----------------------------------------------------------------------------
// IPMB frame check and classify testbench
// Streams IPMB frames into the checker byte by byte; both channels stall at
// random except in the last phase. A frame tracker predicts each verdict, and
// every result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipmb_frame_check_classify_tb;

    import ipmb_fcc_pkg::*;

    localparam int MAX_BYTES    = DEFAULT_MAX_FRAME_BYTES;
    localparam int DRAIN_CYCLES = 8;

    typedef struct {
        status_t    status;
        logic       is_event;
        logic [5:0] net_function;
        logic [7:0] source_address;
        logic [5:0] request_sequence;
        logic [7:0] command_code;
        logic [6:0] frame_length;
    } frame_verdict_t;

    logic clk;
    logic rst_n;

    ipmb_fcc_byte_if   frame_ch ();
    ipmb_fcc_result_if result_ch ();

    ipmb_frame_check_classify #(
        .MAX_FRAME_BYTES (MAX_BYTES)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch)
    );

    frame_verdict_t pending_verdicts[$];
    logic [7:0]     frame_bytes[$];

    // Tracked frame state
    int         rx_count      = 0;
    logic       rx_overflow   = 1'b0;
    logic [7:0] rx_header_sum = 8'h00;
    logic [7:0] rx_body_sum   = 8'h00;
    logic [5:0] rx_netfn      = 6'h00;
    logic [7:0] rx_source     = 8'h00;
    logic [5:0] rx_sequence   = 6'h00;
    logic [7:0] rx_command    = 8'h00;

    int src_idle_pct   = 0;
    int snk_idle_pct   = 0;
    int fail_count     = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int results_seen   = 0;
    int events_seen    = 0;
    int status_seen[5] = '{default: 0};

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("** ipmb_frame_check_classify: FAILED **");
        $finish;
    end

    task automatic track_frame_byte(input logic [7:0] value, input logic is_last);
        frame_verdict_t v;
        if (rx_count >= MAX_BYTES)
        begin
            rx_overflow = 1'b1;
        end
        else
        begin
            if (rx_count < HEADER_BYTES)
                rx_header_sum = rx_header_sum + value;
            else
                rx_body_sum = rx_body_sum + value;
            case (rx_count)
                POS_NETFN:    rx_netfn    = value[7:2];
                POS_SOURCE:   rx_source   = value;
                POS_SEQUENCE: rx_sequence = value[7:2];
                POS_COMMAND:  rx_command  = value;
                default:      ;
            endcase
            rx_count++;
        end
        if (is_last)
        begin
            if (rx_overflow)
                v.status = STATUS_TOO_LONG;
            else if (rx_count < HEADER_BYTES)
                v.status = STATUS_TOO_SHORT;
            else if (rx_header_sum != 8'h00)
                v.status = STATUS_HEADER_BAD;
            else if (rx_body_sum != 8'h00)
                v.status = STATUS_BODY_BAD;
            else
                v.status = STATUS_OK;
            v.is_event         = (rx_netfn == EVENT_NETFN) && (rx_command == EVENT_COMMAND);
            v.net_function     = rx_netfn;
            v.source_address   = rx_source;
            v.request_sequence = rx_sequence;
            v.command_code     = rx_command;
            v.frame_length     = 7'(rx_count);
            pending_verdicts.push_back(v);
            rx_count      = 0;
            rx_overflow   = 1'b0;
            rx_header_sum = 8'h00;
            rx_body_sum   = 8'h00;
            rx_netfn      = 6'h00;
            rx_source     = 8'h00;
            rx_sequence   = 6'h00;
            rx_command    = 8'h00;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // Result side: check each transfer, then pick the next ready level
    initial
    begin
        frame_verdict_t want;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("result transfer with no frame outstanding");
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    check_field("status", want.status, result_ch.status);
                    check_field("is_event", want.is_event, result_ch.is_event);
                    check_field("net_function", want.net_function, result_ch.net_function);
                    check_field("source_address", want.source_address,
                                result_ch.source_address);
                    check_field("request_sequence", want.request_sequence,
                                result_ch.request_sequence);
                    check_field("command_code", want.command_code, result_ch.command_code);
                    check_field("frame_length", want.frame_length, result_ch.frame_length);
                    results_seen++;
                    status_seen[int'(want.status)]++;
                    if (want.is_event)
                        events_seen++;
                end
            end
            result_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid     <= 1'b1;
        frame_ch.data_byte <= value;
        frame_ch.last      <= is_last;
        do
            @(posedge clk);
        while (!frame_ch.ready);
        track_frame_byte(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    // Fill frame_bytes with random content, optionally with proper checksums
    task automatic make_frame(input int len, input logic [5:0] netfn, input logic [7:0] cmd,
                              input bit fix_sums, input bit break_header,
                              input bit break_body);
        logic [7:0] sum;
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(8'($urandom));
        if (len > POS_NETFN)
            frame_bytes[POS_NETFN] = {netfn, frame_bytes[POS_NETFN][1:0]};
        if (len > POS_COMMAND)
            frame_bytes[POS_COMMAND] = cmd;
        if (fix_sums && len >= HEADER_BYTES)
        begin
            sum = frame_bytes[0] + frame_bytes[1];
            frame_bytes[HEADER_BYTES - 1] = 8'h00 - sum;
            if (break_header)
                frame_bytes[HEADER_BYTES - 1] = frame_bytes[HEADER_BYTES - 1]
                                                + 8'($urandom_range(1, 255));
            if (len > HEADER_BYTES)
            begin
                sum = 8'h00;
                for (int i = HEADER_BYTES; i < len - 1; i++)
                    sum = sum + frame_bytes[i];
                frame_bytes[len - 1] = 8'h00 - sum;
                if (break_body)
                    frame_bytes[len - 1] = frame_bytes[len - 1] + 8'($urandom_range(1, 255));
            end
        end
    endtask

    task automatic drain_results();
        frame_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_verdicts.size() != 0);
    endtask

    task automatic test_directed_cases();
        frame_bytes = {8'hFF};
        send_frame();
        frame_bytes = {8'h00, 8'hFC};
        send_frame();
        frame_bytes = {8'h00, 8'h00, 8'h00};
        send_frame();
        frame_bytes = {8'hFF, 8'hFF, 8'hFF};
        send_frame();
        make_frame(7, EVENT_NETFN, EVENT_COMMAND, 1'b1, 1'b0, 1'b0);
        send_frame();
        make_frame(7, EVENT_NETFN, EVENT_COMMAND, 1'b1, 1'b0, 1'b1);
        send_frame();
        make_frame(4, 6'h00, 8'h00, 1'b1, 1'b1, 1'b1);
        send_frame();
    endtask

    task automatic test_frame_length_limits();
        make_frame(MAX_BYTES, 6'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0);
        send_frame();
        make_frame(MAX_BYTES + 1, EVENT_NETFN, EVENT_COMMAND, 1'b1, 1'b1, 1'b0);
        send_frame();
    endtask

    task automatic test_pause_until_drained();
        make_frame(6, 6'($urandom), 8'($urandom), 1'b1, 1'b0, 1'b0);
        send_frame();
        drain_results();
        make_frame(8, EVENT_NETFN, EVENT_COMMAND, 1'b1, 1'b0, 1'b0);
        send_frame();
    endtask

    task automatic test_random_frames(input int byte_budget);
        int         stop_at;
        int         kind;
        bit         evt;
        logic [5:0] nf;
        logic [7:0] cmd;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at)
        begin
            kind = $urandom_range(99);
            evt  = ($urandom_range(3) == 0);
            nf   = evt ? EVENT_NETFN : 6'($urandom);
            cmd  = evt ? EVENT_COMMAND : 8'($urandom);
            if (kind < 6)
                make_frame($urandom_range(1, 2), nf, cmd, 1'b0, 1'b0, 1'b0);
            else if (kind < 8)
                make_frame($urandom_range(MAX_BYTES - 2, MAX_BYTES + 3), nf, cmd,
                           1'b1, 1'b0, 1'b0);
            else if (kind < 14)
                make_frame($urandom_range(1, 12), nf, cmd, 1'b0, 1'b0, 1'b0);
            else if (kind < 24)
                make_frame($urandom_range(3, 16), nf, cmd, 1'b1, 1'b1, 1'b0);
            else if (kind < 34)
                make_frame($urandom_range(4, 16), nf, cmd, 1'b1, 1'b0, 1'b1);
            else
                make_frame($urandom_range(3, 16), nf, cmd, 1'b1, 1'b0, 1'b0);
            send_frame();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        frame_ch.valid     <= 1'b0;
        frame_ch.data_byte <= 8'h00;
        frame_ch.last      <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        src_idle_pct = 11;
        snk_idle_pct = 86;
        test_directed_cases();
        test_random_frames(130);
        test_pause_until_drained();

        src_idle_pct = 86;
        snk_idle_pct = 11;
        test_frame_length_limits();
        test_random_frames(130);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        test_random_frames(130);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d frames under three stall patterns; checked %0d results.",
                 bytes_sent, frames_sent, results_seen);
        $display("Verdicts: ok %0d, header bad %0d, body bad %0d, short %0d, long %0d; events %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], events_seen);
        if (fail_count == 0 && pending_verdicts.size() == 0)
            $display("** ipmb_frame_check_classify: PASSED **");
        else
            $display("** ipmb_frame_check_classify: FAILED **");
        $finish;
    end

endmodule
